// ===== rtl/dbl_pkg.sv =====
package dbl_pkg;

	// field widths fixed by the interface
	localparam int OP_W       = 2;
	localparam int IDX_W      = 2;
	localparam int DUR_W      = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_ADDR_W = 4;

	// operation codes as they arrive on the input channel
	localparam logic [OP_W-1:0] OPC_TICK = 2'd0;
	localparam logic [OP_W-1:0] OPC_READ = 2'd1;
	localparam logic [OP_W-1:0] OPC_BEEP = 2'd2;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE = 4'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_LONG     = 4'd1;

	// configuration reset values
	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [CFG_W-1:0] LONG_RESET     = 16'd800;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_TICK,
		OP_READ,
		OP_BEEP,
		OP_NOP
	} op_t;

	// pending press code
	typedef enum logic [1:0] {
		PRESS_NONE  = 2'd0,
		PRESS_SHORT = 2'd1,
		PRESS_LONG  = 2'd2
	} press_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

endpackage

// ===== rtl/dbl_front.sv =====
module dbl_front #(
	parameter int NUM_BUTTONS = 3,
	parameter int COUNT_WIDTH = 16
) (
	input  logic [dbl_pkg::OP_W-1:0]  operation,
	input  logic [dbl_pkg::IDX_W-1:0] button_index,
	input  logic [dbl_pkg::DUR_W-1:0] beep_duration,
	output dbl_pkg::cmd_t             cmd,
	output logic [COUNT_WIDTH-1:0]    dur
);
	import dbl_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > DUR_W) ? COUNT_WIDTH : DUR_W;
	localparam logic [CMP_W-1:0] DUR_LIMIT = CMP_W'({COUNT_WIDTH{1'b1}});

	logic [CMP_W-1:0] dur_wide;

	// classify the operation; a read of a missing button does nothing
	always_comb begin
		cmd.idx = button_index;
		unique case (operation)
			OPC_TICK: cmd.op = OP_TICK;
			OPC_READ: cmd.op = (int'(button_index) < NUM_BUTTONS) ? OP_READ : OP_NOP;
			OPC_BEEP: cmd.op = OP_BEEP;
			default:  cmd.op = OP_NOP;
		endcase
	end

	// clamp the beep duration to the counter range
	assign dur_wide = CMP_W'(beep_duration);
	assign dur      = (dur_wide > DUR_LIMIT) ? COUNT_WIDTH'(DUR_LIMIT)
	                                         : COUNT_WIDTH'(dur_wide);

endmodule

// ===== rtl/dbl_queue.sv =====
module dbl_queue #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);
	logic [DATA_W-1:0] slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// two-entry ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/dbl_back.sv =====
module dbl_back #(
	parameter int NUM_BUTTONS = 3,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [dbl_pkg::CFG_ADDR_W-1:0] cfg_index,
	input  logic [dbl_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           q_valid,
	output logic                           q_ready,
	input  dbl_pkg::cmd_t                  q_cmd,
	input  logic [NUM_BUTTONS-1:0]         q_levels,
	input  logic [COUNT_WIDTH-1:0]         q_dur,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     press_kind,
	output logic                           buzzer_level
);
	import dbl_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic [CFG_W-1:0]       debounce_q;
	logic [CFG_W-1:0]       long_q;
	logic [NUM_BUTTONS-1:0] last_q;
	logic [NUM_BUTTONS-1:0] held_q;
	logic [COUNT_WIDTH-1:0] quiet_q [NUM_BUTTONS];
	logic [COUNT_WIDTH-1:0] hold_q  [NUM_BUTTONS];
	press_t                 pend_q  [NUM_BUTTONS];
	logic                   active_q;
	logic [COUNT_WIDTH-1:0] remain_q;
	logic                   out_valid_q;
	logic [1:0]             kind_q;
	logic                   buzz_q;

	logic [COUNT_WIDTH-1:0] hold_inc  [NUM_BUTTONS];
	logic [COUNT_WIDTH-1:0] quiet_inc [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] long_ok;
	logic [NUM_BUTTONS-1:0] start_hold;
	logic [NUM_BUTTONS-1:0] release_hit;
	logic [NUM_BUTTONS-1:0] sel;
	logic [COUNT_WIDTH-1:0] remain_dec;
	logic                   pop;
	logic                   buzz_nx;
	logic [1:0]             kind_nx;

	assign pop     = q_valid && q_ready;
	assign q_ready = !out_valid_q || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			long_q     <= LONG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEBOUNCE: debounce_q <= cfg_data;
				CFG_LONG:     long_q     <= cfg_data;
				default:      ;
			endcase
		end
	end

	// per-button tick update, all buttons in parallel
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			hold_inc[i]  = (held_q[i] && hold_q[i] != CNT_MAX) ? hold_q[i] + 1'b1
			                                                   : hold_q[i];
			quiet_inc[i] = (q_levels[i] != last_q[i]) ? '0 :
			               (quiet_q[i] == CNT_MAX) ? CNT_MAX : quiet_q[i] + 1'b1;
			long_ok[i]   = CMP_W'(hold_inc[i]) >= CMP_W'(long_q);
			start_hold[i]  = (CMP_W'(quiet_inc[i]) >= CMP_W'(debounce_q))
			                 && !q_levels[i] && !held_q[i];
			release_hit[i] = (CMP_W'(quiet_inc[i]) >= CMP_W'(debounce_q))
			                 && q_levels[i] && held_q[i];
			sel[i] = (int'(q_cmd.idx) == i);
		end
	end

	// buzzer countdown and read result
	assign remain_dec = (remain_q != '0) ? remain_q - 1'b1 : remain_q;

	always_comb begin
		kind_nx = 2'd0;
		unique case (q_cmd.op)
			OP_TICK: buzz_nx = active_q && (remain_dec != '0);
			OP_BEEP: buzz_nx = 1'b1;
			default: buzz_nx = active_q;
		endcase
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (q_cmd.op == OP_READ && sel[i]) begin
				kind_nx = kind_nx | pend_q[i];
			end
		end
	end

	// button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '1;
			held_q <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				quiet_q[i] <= CNT_MAX;
				hold_q[i]  <= '0;
				pend_q[i]  <= PRESS_NONE;
			end
		end else if (pop) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (q_cmd.op == OP_TICK) begin
					last_q[i]  <= q_levels[i];
					quiet_q[i] <= quiet_inc[i];
					hold_q[i]  <= start_hold[i] ? '0 : hold_inc[i];
					held_q[i]  <= start_hold[i] || (held_q[i] && !release_hit[i]);
					if (release_hit[i]) begin
						pend_q[i] <= long_ok[i] ? PRESS_LONG : PRESS_SHORT;
					end
				end else if (q_cmd.op == OP_READ && sel[i]) begin
					pend_q[i] <= PRESS_NONE;
				end
			end
		end
	end

	// buzzer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			remain_q <= '0;
		end else if (pop) begin
			active_q <= buzz_nx;
			if (q_cmd.op == OP_BEEP) begin
				remain_q <= q_dur;
			end else if (q_cmd.op == OP_TICK && active_q) begin
				remain_q <= remain_dec;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_ready) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= kind_nx;
			buzz_q <= buzz_nx;
		end
	end

	assign out_valid    = out_valid_q;
	assign press_kind   = kind_q;
	assign buzzer_level = buzz_q;

endmodule

// ===== rtl/button_debounce_long_press.sv =====
// Debouncer with long-press detection for NUM_BUTTONS active-low buttons and a
// buzzer with timed auto-off. Each input item is a tick carrying sampled pin
// levels, a read-and-clear of one button's pending press (0 none, 1 short,
// 2 long), or a beep start; every item returns exactly one result with the
// press code (reads only, else 0) and the buzzer level after the item. Time is
// counted in ticks. The block takes one item per clock cycle and returns one
// result per cycle while out_ready stays high; results pass through the
// two-entry queue and the output register. Configuration (debounce and
// long-press tick counts) is always ready and should be written while idle.
module button_debounce_long_press #(
	parameter int NUM_BUTTONS = 3,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [dbl_pkg::OP_W-1:0]       operation,
	input  logic [NUM_BUTTONS-1:0]         raw_levels,
	input  logic [dbl_pkg::IDX_W-1:0]      button_index,
	input  logic [dbl_pkg::DUR_W-1:0]      beep_duration,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     press_kind,
	output logic                           buzzer_level,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dbl_pkg::CFG_ADDR_W-1:0] cfg_index,
	input  logic [dbl_pkg::CFG_W-1:0]      cfg_data
);
	import dbl_pkg::*;

	localparam int Q_W = CMD_W + NUM_BUTTONS + COUNT_WIDTH;

	cmd_t                   f_cmd;
	logic [COUNT_WIDTH-1:0] f_dur;
	logic [Q_W-1:0]         q_data;
	logic                   q_valid;
	logic                   q_ready;
	cmd_t                   q_cmd;
	logic [NUM_BUTTONS-1:0] q_levels;
	logic [COUNT_WIDTH-1:0] q_dur;

	assign cfg_ready = 1'b1;

	// classify incoming items
	dbl_front #(
		.NUM_BUTTONS(NUM_BUTTONS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.operation    (operation),
		.button_index (button_index),
		.beep_duration(beep_duration),
		.cmd          (f_cmd),
		.dur          (f_dur)
	);

	// decoupling queue
	dbl_queue #(
		.DATA_W(Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(in_valid),
		.push_ready(in_ready),
		.push_data ({f_cmd, raw_levels, f_dur}),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_data  (q_data)
	);

	assign {q_cmd, q_levels, q_dur} = q_data;

	// execute items on button and buzzer state
	dbl_back #(
		.NUM_BUTTONS(NUM_BUTTONS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_cmd       (q_cmd),
		.q_levels    (q_levels),
		.q_dur       (q_dur),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.press_kind  (press_kind),
		.buzzer_level(buzzer_level)
	);

	// an empty queue always takes an item
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_valid)
		else $error("input stalled with empty queue");

	// every item leaving the queue shows up as a result
	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |=> out_valid)
		else $error("popped item produced no result");

	// a taken result with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !q_valid) |=> !out_valid)
		else $error("result repeated");

	// press code never takes the unused value
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (press_kind != 2'd3))
		else $error("bad press code");

endmodule
